// ===== hw/rtl/battery_level_averager_defines.svh =====
// ----------------------------------------------------------------------------
// Battery level averager assertion macros
// Shared property wrappers clocked on aclk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef BATTERY_LEVEL_AVERAGER_DEFINES_SVH
`define BATTERY_LEVEL_AVERAGER_DEFINES_SVH

// Check a consequence in the same cycle as its cause
`define BLA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its cause
`define BLA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/bla_pkg.sv =====
// ----------------------------------------------------------------------------
// Battery level averager package
// Field widths, register map, reset values and arithmetic constants.
// ----------------------------------------------------------------------------
package bla_pkg;

    // Parameter defaults
    localparam int DEFAULT_MAX_SAMPLES = 256;
    localparam int DEFAULT_ADC_BITS    = 10;

    // Register field widths
    localparam int TGT_W   = 9;
    localparam int TICK_W  = 16;
    localparam int RATIO_W = 12;
    localparam int MV_W    = 14;
    localparam int PCT_W   = 7;

    // APB port
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 3;

    // Register indexes (byte address / 4)
    localparam logic [REG_IDX_W-1:0] REG_TARGET   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_INTERVAL = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_DELAY    = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_RATIO    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_EMPTY    = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_FULL     = 3'd5;

    // Register reset values
    localparam logic [TGT_W-1:0]   RST_TARGET   = 9'd10;
    localparam logic [TICK_W-1:0]  RST_INTERVAL = 16'd10;
    localparam logic [TICK_W-1:0]  RST_DELAY    = 16'd1000;
    localparam logic [RATIO_W-1:0] RST_RATIO    = 12'd1024;
    localparam logic [MV_W-1:0]    RST_EMPTY    = 14'd3300;
    localparam logic [MV_W-1:0]    RST_FULL     = 14'd4200;

    // Arithmetic constants
    localparam logic [TICK_W-1:0] COUNTER_MAX = 16'hFFFF;
    localparam logic [MV_W-1:0]   MV_MAX      = 14'h3FFF;
    localparam int                MV_SCALE    = 1000;
    localparam int                MV_SCALE_W  = 10;
    localparam int                PCT_FULL    = 100;
    localparam int                RATIO_FRAC  = 8;

    // Serial multiplier operand width (ratio times millivolt scale)
    localparam int K_W    = RATIO_W + MV_SCALE_W;
    localparam int STEP_W = $clog2(K_W + 1);

endpackage

// ===== hw/rtl/battery_level_averager.sv =====
// ----------------------------------------------------------------------------
// Battery level averager
// Averages converter readings over a round and gauges the battery charge.
// ----------------------------------------------------------------------------
// Each input beat is one millisecond tick carrying the current converter
// reading; each tick gives exactly one output beat with the held millivolts,
// the held percentage and the round status. A tick that does not complete a
// round is accepted and its result beat is registered at the accepting
// edge, so such ticks can follow every cycle while the output side keeps up.
// A tick that completes a round starts the bit-serial arithmetic unit: a
// shift-add multiplier takes one bit of the 22-bit scale per cycle, then one
// restoring divider produces one quotient bit per cycle, 14 bits of
// millivolts and 7 bits of percentage, with a setup state (ST_OVF, ST_PCT)
// before each and a final state (ST_DONE) that loads the result beat. The
// millivolt division is skipped when the millivolts saturate, the percentage
// division when it clamps, and no tick is taken until the beat is loaded.
// ----------------------------------------------------------------------------
`include "battery_level_averager_defines.svh"

module battery_level_averager #(
    parameter int MAX_SAMPLES = bla_pkg::DEFAULT_MAX_SAMPLES,
    parameter int ADC_BITS    = bla_pkg::DEFAULT_ADC_BITS
) (
    input  logic                            aclk,
    input  logic                            aresetn,

    // Tick stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [((ADC_BITS+7)/8)*8-1:0]   s_tdata,  // [ADC_BITS-1:0] adc_sample
    // Result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [13:0] battery_mv, [20:14] battery_percent
    output logic [((bla_pkg::MV_W+bla_pkg::PCT_W+7)/8)*8-1:0] m_tdata,
    output logic [1:0]                      m_tuser,  // [0] round_complete, [1] round_finished_now

    // Configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [bla_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [bla_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [bla_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);

    import bla_pkg::*;

    localparam int N_W        = $clog2(MAX_SAMPLES + 1);
    localparam int SUM_W      = ADC_BITS + N_W;
    localparam int DEN_W      = N_W + ADC_BITS;
    localparam int PROD_W     = SUM_W + K_W;
    localparam int NUMQ_W     = PROD_W - RATIO_FRAC;
    localparam int PCT_NUM_W  = MV_W + PCT_W;
    localparam int DIV_A      = (NUMQ_W > DEN_W + MV_W) ? NUMQ_W : DEN_W + MV_W;
    localparam int DIV_W      = (DIV_A > PCT_NUM_W) ? DIV_A : PCT_NUM_W;
    localparam int CMP_W      = (TGT_W > N_W) ? TGT_W : N_W;
    localparam int OUT_DATA_W = ((MV_W + PCT_W + 7) / 8) * 8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_OVF,
        ST_DIV,
        ST_PCT,
        ST_PDIV,
        ST_DONE
    } state_t;

    // Configuration registers
    logic [TGT_W-1:0]   cfg_target_reg;
    logic [TICK_W-1:0]  cfg_interval_reg;
    logic [TICK_W-1:0]  cfg_delay_reg;
    logic [RATIO_W-1:0] cfg_ratio_reg;
    logic [MV_W-1:0]    cfg_empty_reg;
    logic [MV_W-1:0]    cfg_full_reg;

    // Round state
    state_t             state_reg;
    logic [SUM_W-1:0]   sum_reg, sum_next, sum_add;
    logic [N_W-1:0]     count_reg, count_next, count_inc;
    logic [TICK_W-1:0]  tsr_reg, tsr_next, tsr_bump;
    logic [TICK_W-1:0]  tsc_reg, tsc_next, tsc_bump;
    logic               complete_reg, complete_next;
    logic               restart_reg, restart_next;
    logic [MV_W-1:0]    held_mv_reg;
    logic [PCT_W-1:0]   held_pct_reg;
    logic [STEP_W-1:0]  step_reg;
    logic               m_tvalid_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;
    logic [1:0]         m_tuser_reg;

    // Arithmetic unit
    logic [PROD_W-1:0]  acc_reg;
    logic [PROD_W-1:0]  mcand_reg;
    logic [K_W-1:0]     mplier_reg;
    logic [DEN_W-1:0]   den_reg;
    logic [DIV_W-1:0]   rem_reg;
    logic [DIV_W-1:0]   dvs_reg;
    logic [MV_W-1:0]    quot_reg;

    logic               cfg_wr;
    logic               s_accept;
    logic [ADC_BITS-1:0] sample;
    logic [N_W-1:0]     eff_n;
    logic [DEN_W-1:0]   den_calc;
    logic               busy, start, take, finish;
    logic               load_beat;
    logic               div_ge;
    logic [MV_W-1:0]    quot_shift;
    logic [NUMQ_W-1:0]  numq;
    logic               mv_ovf;

    // ------------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    // Write registers on the access cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_target_reg   <= RST_TARGET;
            cfg_interval_reg <= RST_INTERVAL;
            cfg_delay_reg    <= RST_DELAY;
            cfg_ratio_reg    <= RST_RATIO;
            cfg_empty_reg    <= RST_EMPTY;
            cfg_full_reg     <= RST_FULL;
        end else if (cfg_wr) begin
            unique case (paddr[APB_ADDR_W-1:2])
                REG_TARGET:   cfg_target_reg   <= pwdata[TGT_W-1:0];
                REG_INTERVAL: cfg_interval_reg <= pwdata[TICK_W-1:0];
                REG_DELAY:    cfg_delay_reg    <= pwdata[TICK_W-1:0];
                REG_RATIO:    cfg_ratio_reg    <= pwdata[RATIO_W-1:0];
                REG_EMPTY:    cfg_empty_reg    <= pwdata[MV_W-1:0];
                REG_FULL:     cfg_full_reg     <= pwdata[MV_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back register values
    always_comb begin
        unique case (paddr[APB_ADDR_W-1:2])
            REG_TARGET:   prdata = APB_DATA_W'(cfg_target_reg);
            REG_INTERVAL: prdata = APB_DATA_W'(cfg_interval_reg);
            REG_DELAY:    prdata = APB_DATA_W'(cfg_delay_reg);
            REG_RATIO:    prdata = APB_DATA_W'(cfg_ratio_reg);
            REG_EMPTY:    prdata = APB_DATA_W'(cfg_empty_reg);
            REG_FULL:     prdata = APB_DATA_W'(cfg_full_reg);
            default:      prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------------
    // Tick decode
    // ------------------------------------------------------------------------
    assign s_tready = (state_reg == ST_IDLE) && (!m_tvalid_reg || m_tready);
    assign s_accept = s_tvalid && s_tready;
    assign sample   = s_tdata[ADC_BITS-1:0];

    // Clamp the target to 1..MAX_SAMPLES
    always_comb begin
        if (cfg_target_reg == '0) begin
            eff_n = N_W'(1);
        end else if (CMP_W'(cfg_target_reg) > CMP_W'(MAX_SAMPLES)) begin
            eff_n = N_W'(MAX_SAMPLES);
        end else begin
            eff_n = N_W'(CMP_W'(cfg_target_reg));
        end
    end

    // Full-scale denominator: n * (2^ADC_BITS - 1)
    assign den_calc = DEN_W'({eff_n, {ADC_BITS{1'b0}}}) - DEN_W'(eff_n);

    // Saturate the elapsed counters
    assign tsr_bump = (tsr_reg == COUNTER_MAX) ? tsr_reg : tsr_reg + TICK_W'(1);
    assign tsc_bump = (tsc_reg == COUNTER_MAX) ? tsc_reg : tsc_reg + TICK_W'(1);

    assign busy      = complete_reg && (tsc_bump < cfg_delay_reg);
    assign start     = !busy && (restart_reg || complete_reg);
    assign take      = !busy && !start && (tsr_bump >= cfg_interval_reg);
    assign sum_add   = sum_reg + SUM_W'(sample);
    assign count_inc = (count_reg < eff_n) ? count_reg + N_W'(1) : count_reg;
    assign finish    = take && (count_inc >= eff_n);

    // A result beat loads on a plain tick or at the end of the arithmetic
    assign load_beat = (s_accept && !finish) || (state_reg == ST_DONE);

    // Next round state for an accepted tick
    always_comb begin
        sum_next      = sum_reg;
        count_next    = count_reg;
        tsr_next      = tsr_bump;
        tsc_next      = tsc_bump;
        complete_next = complete_reg;
        restart_next  = restart_reg;
        priority if (start) begin
            sum_next      = '0;
            count_next    = '0;
            tsr_next      = '0;
            complete_next = 1'b0;
            restart_next  = 1'b0;
        end else if (take) begin
            tsr_next   = '0;
            sum_next   = sum_add;
            count_next = count_inc;
            if (finish) begin
                complete_next = 1'b1;
                tsc_next      = '0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Serial arithmetic helpers
    // ------------------------------------------------------------------------
    assign div_ge     = (rem_reg >= dvs_reg);
    assign quot_shift = {quot_reg[MV_W-2:0], div_ge};
    assign numq       = acc_reg[PROD_W-1:RATIO_FRAC];
    assign mv_ovf     = (DIV_W'(numq) >= (DIV_W'(den_reg) << MV_W));

    // ------------------------------------------------------------------------
    // Sequencer, round state and result beat
    // ------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            sum_reg      <= '0;
            count_reg    <= '0;
            tsr_reg      <= '0;
            tsc_reg      <= '0;
            complete_reg <= 1'b0;
            restart_reg  <= 1'b1;
            held_mv_reg  <= '0;
            held_pct_reg <= '0;
            step_reg     <= '0;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
            m_tuser_reg  <= '0;
        end else begin
            // Load a new beat, else drop the one just taken
            if (load_beat) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_accept) begin
                        sum_reg      <= sum_next;
                        count_reg    <= count_next;
                        tsr_reg      <= tsr_next;
                        tsc_reg      <= tsc_next;
                        complete_reg <= complete_next;
                        restart_reg  <= restart_next;
                        if (finish) begin
                            step_reg  <= '0;
                            state_reg <= ST_MUL;
                        end else begin
                            m_tdata_reg  <= OUT_DATA_W'({held_pct_reg, held_mv_reg});
                            m_tuser_reg  <= {1'b0, complete_next};
                        end
                    end
                end
                ST_MUL: begin
                    step_reg <= step_reg + STEP_W'(1);
                    if (step_reg == STEP_W'(K_W - 1)) begin
                        state_reg <= ST_OVF;
                    end
                end
                ST_OVF: begin
                    step_reg <= '0;
                    if (mv_ovf) begin
                        held_mv_reg <= MV_MAX;
                        state_reg   <= ST_PCT;
                    end else begin
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV: begin
                    step_reg <= step_reg + STEP_W'(1);
                    if (step_reg == STEP_W'(MV_W - 1)) begin
                        held_mv_reg <= quot_shift;
                        state_reg   <= ST_PCT;
                    end
                end
                ST_PCT: begin
                    step_reg <= '0;
                    priority if (held_mv_reg <= cfg_empty_reg) begin
                        held_pct_reg <= '0;
                        state_reg    <= ST_DONE;
                    end else if (held_mv_reg >= cfg_full_reg) begin
                        held_pct_reg <= PCT_W'(PCT_FULL);
                        state_reg    <= ST_DONE;
                    end else begin
                        state_reg <= ST_PDIV;
                    end
                end
                ST_PDIV: begin
                    step_reg <= step_reg + STEP_W'(1);
                    if (step_reg == STEP_W'(PCT_W - 1)) begin
                        held_pct_reg <= quot_shift[PCT_W-1:0];
                        state_reg    <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    m_tdata_reg  <= OUT_DATA_W'({held_pct_reg, held_mv_reg});
                    m_tuser_reg  <= 2'b11;
                    state_reg    <= ST_IDLE;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Bit-serial multiplier and restoring divider
    // ------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                // Capture operands on each accepted tick, for use if it completes the round
                if (s_accept) begin
                    acc_reg    <= '0;
                    mcand_reg  <= PROD_W'(sum_add);
                    mplier_reg <= K_W'(cfg_ratio_reg) * K_W'(MV_SCALE);
                    den_reg    <= den_calc;
                end
            end
            ST_MUL: begin
                // Add one partial product per multiplier bit
                if (mplier_reg[0]) begin
                    acc_reg <= acc_reg + mcand_reg;
                end
                mcand_reg  <= mcand_reg << 1;
                mplier_reg <= mplier_reg >> 1;
            end
            ST_OVF: begin
                rem_reg  <= DIV_W'(numq);
                dvs_reg  <= DIV_W'(den_reg) << (MV_W - 1);
                quot_reg <= '0;
            end
            ST_DIV, ST_PDIV: begin
                // One restoring step per quotient bit
                if (div_ge) begin
                    rem_reg <= rem_reg - dvs_reg;
                end
                dvs_reg  <= dvs_reg >> 1;
                quot_reg <= quot_shift;
            end
            ST_PCT: begin
                rem_reg  <= DIV_W'(held_mv_reg - cfg_empty_reg) * DIV_W'(PCT_FULL);
                dvs_reg  <= DIV_W'(cfg_full_reg - cfg_empty_reg) << (PCT_W - 1);
                quot_reg <= '0;
            end
            ST_DONE: ;
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    `BLA_ASSERT_NOW(a_done_slot_free, state_reg == ST_DONE, !m_tvalid_reg, "slot busy at end")
    `BLA_ASSERT_NEXT(a_finish_mul, s_accept && finish, state_reg == ST_MUL, "no arith start")
    `BLA_ASSERT_NOW(a_pct_range, m_tvalid_reg, m_tdata_reg[20:14] <= PCT_W'(PCT_FULL), "pct high")
    `BLA_ASSERT_NOW(a_fin_complete, m_tvalid_reg && m_tuser_reg[1], m_tuser_reg[0], "not complete")
    `BLA_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= N_W'(MAX_SAMPLES), "count above maximum")

endmodule
